/* rtl/core/moc_pkg.sv */
// ----------------------------------------------------------------------------
// moc_pkg
// Shared types and constants for the mask overlay compositor.
// ----------------------------------------------------------------------------
package moc_pkg;

  // Line memory depth: the widest supported row.
  localparam int MAX_WIDTH   = 512;
  localparam int HEIGHT_CAP  = 512;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(HEIGHT_CAP);
  localparam int DIM_W       = 10;
  localparam int POS_W       = 9;
  localparam int CH_W        = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);
  localparam logic [DIM_W-1:0]       DIM_RESET        = DIM_W'(500);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CH_W-1:0] CH_FULL = 8'hFF;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h00;

  // Overlay color chosen from the team and recorder flags
  typedef enum logic [1:0] {
    CODE_BASE  = 2'd0,
    CODE_GREEN = 2'd1,
    CODE_RED   = 2'd2,
    CODE_BLUE  = 2'd3
  } code_t;

  typedef struct packed {
    code_t           code;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pixel_t;

  // Emission info for the pixel that leaves with this item
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             y_first;
    logic             y_last;
  } tag_t;

  typedef struct packed {
    pixel_t           pix;
    logic             death;
    logic [COL_W-1:0] col;        // line memory slot of this item
    logic             prev_first; // previous position sits in column 0
    logic             prev_last;  // previous position sits in the last column
    tag_t             tag;
  } work_t;

endpackage

/* rtl/core/moc_if.sv */
// ----------------------------------------------------------------------------
// moc_if
// Stream interfaces of the compositor: pixel input and composited output.
// ----------------------------------------------------------------------------
interface moc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic [7:0] base_alpha;
  logic       team_a_here;
  logic       team_b_here;
  logic       recorder_here;
  logic       death_here;

  modport source (
    output valid, mode, base_red, base_green, base_blue, base_alpha,
           team_a_here, team_b_here, recorder_here, death_here,
    input  ready
  );
  modport sink (
    input  valid, mode, base_red, base_green, base_blue, base_alpha,
           team_a_here, team_b_here, recorder_here, death_here,
    output ready
  );
endinterface

interface moc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic [8:0] column;
  logic [8:0] row;
  logic       frame_last;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, column, row, frame_last,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, column, row, frame_last,
    output ready
  );
endinterface

/* rtl/core/mask_overlay_compositor_3x3.sv */
// ----------------------------------------------------------------------------
// mask_overlay_compositor_3x3
// Raster pixel compositor: team/recorder overlay colors with a 3x3 death
// neighborhood that forces yellow.
// ----------------------------------------------------------------------------
//
//  channel    | dir | handshake     | payload
//  -----------+-----+---------------+---------------------------------------
//  pixels     | in  | valid/ready   | mode, base RGBA, four mask flags
//  composite  | out | valid/ready   | RGBA, column, row, frame_last
//  cfg_*      | in  | cfg_write     | index 0 width, 1 height (10 bits)
//
//  One item per clock sustained while the output is not stalled; the rate
//  is set by the single-port line memories, each touched once per item.
//  A pixel leaves with item width+1 after it; the output register follows
//  that item through the queue, memory read, line 2 read and output stage.
//  Synchronous active-high reset; no clearing pass, a line memory value
//  left from an earlier frame never reaches an emitted pixel.
//  A stalled output freezes the back pipeline; the 4-deep queue keeps the
//  input side taking transactions until it fills.
//
module mask_overlay_compositor_3x3 (
  input  logic                             clk,
  input  logic                             rst,
  moc_in_if.sink                           pixels,
  moc_out_if.source                        composite,
  input  logic                             cfg_write,
  input  logic [moc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [moc_pkg::DIM_W-1:0]        cfg_data
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_nonempty;
  moc_pkg::work_t q_in;
  moc_pkg::work_t q_head;

  // Front: geometry registers, raster counters, color code, emission tag
  moc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full)
  );

  // Decouples input acceptance from output backpressure
  moc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty)
  );

  // Back: line memories, neighborhood OR, compositing, output register
  moc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_nonempty),
    .take       (q_pop),
    .composite  (composite)
  );

`ifndef SYNTHESIS
  // After reset the queue is empty and nothing is offered
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (pixels.ready && !composite.valid))
    else $error("queue or output not empty after reset");

  // A stalled output must freeze the back end
  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (composite.valid && !composite.ready) |-> !q_pop)
    else $error("queue popped while output stalled");

  // An accepted transaction is held in the queue on the next cycle
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready) |=> q_nonempty)
    else $error("accepted transaction lost from queue");

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/core/moc_front.sv */
// ----------------------------------------------------------------------------
// moc_front
// Accepts items, holds the frame geometry and raster counters, and tags
// each item with its color code and the pixel it releases.
// ----------------------------------------------------------------------------
module moc_front (
  input  logic                             clk,
  input  logic                             rst,
  moc_in_if.sink                           pixels,
  input  logic                             cfg_write,
  input  logic [moc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [moc_pkg::DIM_W-1:0]        cfg_data,
  output logic                             push,
  output moc_pkg::work_t                   push_item,
  input  logic                             full
);

  logic [moc_pkg::DIM_W-1:0] width_eff;
  logic [moc_pkg::DIM_W-1:0] height_eff;
  logic [moc_pkg::COL_W-1:0] in_col;
  logic [moc_pkg::DIM_W-1:0] in_row;   // reaches height + 1 while draining
  logic [moc_pkg::COL_W-1:0] out_col;
  logic [moc_pkg::ROW_W-1:0] out_row;

  logic                      accept;
  logic                      cfg_hit;
  logic [moc_pkg::DIM_W-1:0] cap;
  logic [moc_pkg::DIM_W-1:0] clamped;
  logic [moc_pkg::DIM_W-1:0] w_last;
  logic [moc_pkg::DIM_W-1:0] h_last;
  logic                      live;
  logic                      emit;
  logic                      in_wrap;
  logic                      out_wrap;
  logic                      y_last;
  logic                      last_pix;
  moc_pkg::code_t            code;

  assign accept       = pixels.valid & ~full;
  assign pixels.ready = ~full;
  assign push         = accept;

  assign cfg_hit = cfg_write & ((cfg_index == moc_pkg::REG_IMAGE_WIDTH) ||
                                (cfg_index == moc_pkg::REG_IMAGE_HEIGHT));

  // 0 reads as 1, oversize reads as the cap
  always_comb begin
    cap = (cfg_index == moc_pkg::REG_IMAGE_WIDTH) ? moc_pkg::DIM_W'(moc_pkg::MAX_WIDTH)
                                                  : moc_pkg::DIM_W'(moc_pkg::HEIGHT_CAP);
    if (cfg_data == '0) begin
      clamped = moc_pkg::DIM_W'(1);
    end else if (cfg_data > cap) begin
      clamped = cap;
    end else begin
      clamped = cfg_data;
    end
  end

  assign w_last   = width_eff - moc_pkg::DIM_W'(1);
  assign h_last   = height_eff - moc_pkg::DIM_W'(1);
  assign live     = ~pixels.mode & (in_row < height_eff);
  // item index >= width + 1
  assign emit     = (in_row > moc_pkg::DIM_W'(1)) ||
                    ((in_row == moc_pkg::DIM_W'(1)) && (in_col != '0));
  assign in_wrap  = (moc_pkg::DIM_W'(in_col) == w_last);
  assign out_wrap = (moc_pkg::DIM_W'(out_col) == w_last);
  assign y_last   = (moc_pkg::DIM_W'(out_row) == h_last);
  assign last_pix = emit & out_wrap & y_last;

  always_comb begin
    code = moc_pkg::CODE_BASE;
    if (pixels.team_a_here & ~pixels.team_b_here) begin
      code = moc_pkg::CODE_GREEN;
    end else if (pixels.team_b_here & ~pixels.team_a_here) begin
      code = moc_pkg::CODE_RED;
    end
    if (pixels.recorder_here) begin
      code = moc_pkg::CODE_BLUE;
    end
  end

  always_comb begin
    push_item.pix.code   = live ? code : moc_pkg::CODE_BASE;
    push_item.pix.red    = live ? pixels.base_red   : moc_pkg::CH_ZERO;
    push_item.pix.green  = live ? pixels.base_green : moc_pkg::CH_ZERO;
    push_item.pix.blue   = live ? pixels.base_blue  : moc_pkg::CH_ZERO;
    push_item.pix.alpha  = live ? pixels.base_alpha : moc_pkg::CH_ZERO;
    push_item.death      = live & pixels.death_here;
    push_item.col        = in_col;
    push_item.prev_first = (width_eff == moc_pkg::DIM_W'(1)) ||
                           (in_col == moc_pkg::COL_W'(1));
    push_item.prev_last  = (in_col == '0);
    push_item.tag.emit    = emit;
    push_item.tag.last    = last_pix;
    push_item.tag.x       = out_col;
    push_item.tag.y       = out_row;
    push_item.tag.y_first = (out_row == '0);
    push_item.tag.y_last  = y_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= moc_pkg::DIM_RESET;
      height_eff <= moc_pkg::DIM_RESET;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == moc_pkg::REG_IMAGE_WIDTH) begin
        width_eff <= clamped;
      end else begin
        height_eff <= clamped;
      end
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (last_pix) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + moc_pkg::DIM_W'(1);
        end else begin
          in_col <= in_col + moc_pkg::COL_W'(1);
        end
        if (emit) begin
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row + moc_pkg::ROW_W'(1);
          end else begin
            out_col <= out_col + moc_pkg::COL_W'(1);
          end
        end
      end
    end
  end

endmodule

/* rtl/core/moc_queue.sv */
// ----------------------------------------------------------------------------
// moc_queue
// Small register FIFO of tagged items between front and back.
// ----------------------------------------------------------------------------
module moc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  moc_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output moc_pkg::work_t head,
  output logic           nonempty
);

  moc_pkg::work_t              slots [moc_pkg::QUEUE_DEPTH];
  logic [moc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [moc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [moc_pkg::QCNT_W-1:0]  count;

  assign full     = (count == moc_pkg::QCNT_W'(moc_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + moc_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + moc_pkg::QPTR_W'(1);
      end
      if (push & ~pop) begin
        count <= count + moc_pkg::QCNT_W'(1);
      end else if (pop & ~push) begin
        count <= count - moc_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/moc_back.sv */
// ----------------------------------------------------------------------------
// moc_back
// Line memories, 3x3 death neighborhood and color compositing, with the
// output register. Three stages move together under one advance enable.
// ----------------------------------------------------------------------------
module moc_back (
  input  logic           clk,
  input  logic           rst,
  input  moc_pkg::work_t head,
  input  logic           head_valid,
  output logic           take,
  moc_out_if.source      composite
);

  // Horizontal 3-wide death OR, one row and two rows back
  logic                line1 [moc_pkg::MAX_WIDTH];
  logic                line2 [moc_pkg::MAX_WIDTH];
  moc_pkg::pixel_t     pix_mem [moc_pkg::MAX_WIDTH];

  logic                adv;
  logic                d1;
  logic                d2;
  logic                h_new;

  // stage B
  logic                vb;
  moc_pkg::tag_t       tag_b;
  logic [moc_pkg::COL_W-1:0] col_b;
  logic                h_low_b;
  logic                rd1;
  moc_pkg::pixel_t     rdp;
  moc_pkg::pixel_t     pix_last;

  // stage C
  logic                vc;
  moc_pkg::tag_t       tag_c;
  moc_pkg::pixel_t     pix_c;
  logic                h_mid_c;
  logic                h_low_c;
  logic                rd2;
  logic                yellow;
  logic [moc_pkg::CH_W-1:0] r_n, g_n, b_n, a_n;

  // output register
  logic                out_valid;
  logic [moc_pkg::CH_W-1:0] out_r, out_g, out_b, out_a;
  logic [moc_pkg::COL_W-1:0] out_x;
  logic [moc_pkg::ROW_W-1:0] out_y;
  logic                out_last;

  assign adv  = ~(out_valid & ~composite.ready);
  assign take = adv & head_valid;

  // h3 of the previous position, clipped at the row ends
  assign h_new = d1 | (d2 & ~head.prev_first) | (head.death & ~head.prev_last);

  always_ff @(posedge clk) begin
    if (take) begin
      line1[head.col]   <= h_new;
      rd1               <= line1[head.col];
      pix_mem[head.col] <= head.pix;
      rdp               <= pix_mem[head.col];
      d1                <= head.death;
      d2                <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vb) begin
      line2[col_b] <= rd1;
      rd2          <= line2[col_b];
      pix_last     <= rdp;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag_b   <= head.tag;
      col_b   <= head.col;
      h_low_b <= h_new;
    end
    if (adv && vb) begin
      tag_c   <= tag_b;
      pix_c   <= pix_last;
      h_mid_c <= rd1;
      h_low_c <= h_low_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (adv) begin
      vb <= head_valid;
      vc <= vb;
    end
  end

  assign yellow = h_mid_c | (rd2 & ~tag_c.y_first) | (h_low_c & ~tag_c.y_last);

  always_comb begin
    r_n = pix_c.red;
    g_n = pix_c.green;
    b_n = pix_c.blue;
    a_n = pix_c.alpha;
    unique case (pix_c.code)
      moc_pkg::CODE_BASE: begin
      end
      moc_pkg::CODE_GREEN: begin
        r_n = moc_pkg::CH_ZERO; g_n = moc_pkg::CH_FULL;
        b_n = moc_pkg::CH_ZERO; a_n = moc_pkg::CH_FULL;
      end
      moc_pkg::CODE_RED: begin
        r_n = moc_pkg::CH_FULL; g_n = moc_pkg::CH_ZERO;
        b_n = moc_pkg::CH_ZERO; a_n = moc_pkg::CH_FULL;
      end
      moc_pkg::CODE_BLUE: begin
        r_n = moc_pkg::CH_ZERO; g_n = moc_pkg::CH_ZERO;
        b_n = moc_pkg::CH_FULL; a_n = moc_pkg::CH_FULL;
      end
      default: begin
      end
    endcase
    if (yellow) begin
      r_n = moc_pkg::CH_FULL; g_n = moc_pkg::CH_FULL;
      b_n = moc_pkg::CH_ZERO; a_n = moc_pkg::CH_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vc & tag_c.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vc && tag_c.emit) begin
      out_r    <= r_n;
      out_g    <= g_n;
      out_b    <= b_n;
      out_a    <= a_n;
      out_x    <= tag_c.x;
      out_y    <= tag_c.y;
      out_last <= tag_c.last;
    end
  end

  assign composite.valid      = out_valid;
  assign composite.out_red    = out_r;
  assign composite.out_green  = out_g;
  assign composite.out_blue   = out_b;
  assign composite.out_alpha  = out_a;
  assign composite.column     = moc_pkg::POS_W'(out_x);
  assign composite.row        = moc_pkg::POS_W'(out_y);
  assign composite.frame_last = out_last;

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mask_overlay_compositor_3x3. The bench streams
// raster pixels and flush transactions into the block and predicts each
// composited pixel from its own frame model: overlay code, 3x3 death
// neighborhood with edge clipping, output position and end-of-frame flag.
// Both stream sides stall at random. One phase holds the output off long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Run control
  localparam int CYCLE_LIMIT   = 600000;  // watchdog, far above the slowest legal run
  localparam int SETTLE_CYCLES = 12;      // covers the back end plus the 4-deep queue
  localparam int LONG_HOLD     = 300;     // output stall used to fill the block
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 250;

  // One input transaction as the bench sees it
  typedef struct {
    logic                     flush;
    logic [moc_pkg::CH_W-1:0] red, green, blue, alpha;
    logic                     team_a, team_b, recorder, death;
  } pixel_txn_t;

  // One composited output transaction
  typedef struct {
    logic [moc_pkg::CH_W-1:0]  red, green, blue, alpha;
    logic [moc_pkg::POS_W-1:0] column, row;
    logic                      frame_end;
  } composite_t;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [moc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [moc_pkg::DIM_W-1:0]       cfg_data  = '0;
  logic                            rx_ready  = 1'b0;

  always #5 clk = ~clk;

  moc_in_if  pix_if ();
  moc_out_if comp_if ();

  assign comp_if.ready = rx_ready;

  mask_overlay_compositor_3x3 uut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_if),
    .composite (comp_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Frame model
  // Pixels of the current frame are kept by raster position. Every neighbor
  // of the pixel leaving at item t sits at a position <= t, so it has always
  // been written in this frame before it is looked at.
  // --------------------------------------------------------------------------
  logic [moc_pkg::DIM_W-1:0] width_reg  = moc_pkg::DIM_RESET;
  logic [moc_pkg::DIM_W-1:0] height_reg = moc_pkg::DIM_RESET;
  int               frame_pos;   // transactions taken in this frame
  int               emit_col;    // position of the next pixel to leave
  int               emit_row;
  logic             death_map [moc_pkg::MAX_WIDTH*moc_pkg::HEIGHT_CAP];
  moc_pkg::pixel_t  pixel_map [moc_pkg::MAX_WIDTH*moc_pkg::HEIGHT_CAP];

  composite_t       composites_due [$];
  int unsigned      error_count;
  int unsigned      items_sent;

  // Out-of-range sizes: zero acts as one, anything past the cap as the cap
  function automatic int clamp_dim(logic [moc_pkg::DIM_W-1:0] raw, int cap);
    if (raw == '0) return 1;
    if (int'(raw) > cap) return cap;
    return int'(raw);
  endfunction

  function automatic int active_width();
    return clamp_dim(width_reg, moc_pkg::MAX_WIDTH);
  endfunction

  function automatic int active_height();
    return clamp_dim(height_reg, moc_pkg::HEIGHT_CAP);
  endfunction

  // Transactions in one full frame: every pixel plus the width+1 drain slots
  function automatic int frame_items();
    return active_width() * active_height() + active_width() + 1;
  endfunction

  function automatic void predict_composite(pixel_txn_t txn);
    int              w, h, t, total, nx, ny;
    logic            live, yellow;
    moc_pkg::pixel_t pix, held;
    composite_t      res;
    w     = active_width();
    h     = active_height();
    total = w * h;
    t     = frame_pos;
    live  = !txn.flush && (t < total);

    // A flush inside the image stores a blank pixel; data past the image is dropped
    if (t < total) begin
      pix = '0;
      if (live) begin
        pix.red   = txn.red;
        pix.green = txn.green;
        pix.blue  = txn.blue;
        pix.alpha = txn.alpha;
        if (txn.team_a && !txn.team_b) pix.code = moc_pkg::CODE_GREEN;
        else if (txn.team_b && !txn.team_a) pix.code = moc_pkg::CODE_RED;
        if (txn.recorder) pix.code = moc_pkg::CODE_BLUE;
      end
      pixel_map[t] = pix;
      death_map[t] = live & txn.death;
    end

    // Nothing leaves until the row below and one more pixel have arrived
    if (t < w + 1) begin
      frame_pos = t + 1;
      return;
    end

    held   = pixel_map[t - w - 1];
    yellow = 1'b0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = emit_col + dx;
        ny = emit_row + dy;
        if (nx >= 0 && nx < w && ny >= 0 && ny < h && death_map[ny * w + nx])
          yellow = 1'b1;
      end
    end

    res.red   = held.red;
    res.green = held.green;
    res.blue  = held.blue;
    res.alpha = held.alpha;
    case (held.code)
      moc_pkg::CODE_GREEN: begin
        {res.red, res.green, res.blue, res.alpha} =
          {moc_pkg::CH_ZERO, moc_pkg::CH_FULL, moc_pkg::CH_ZERO, moc_pkg::CH_FULL};
      end
      moc_pkg::CODE_RED: begin
        {res.red, res.green, res.blue, res.alpha} =
          {moc_pkg::CH_FULL, moc_pkg::CH_ZERO, moc_pkg::CH_ZERO, moc_pkg::CH_FULL};
      end
      moc_pkg::CODE_BLUE: begin
        {res.red, res.green, res.blue, res.alpha} =
          {moc_pkg::CH_ZERO, moc_pkg::CH_ZERO, moc_pkg::CH_FULL, moc_pkg::CH_FULL};
      end
      default: ;
    endcase
    // Death anywhere in the neighborhood beats every overlay
    if (yellow)
      {res.red, res.green, res.blue, res.alpha} =
        {moc_pkg::CH_FULL, moc_pkg::CH_FULL, moc_pkg::CH_ZERO, moc_pkg::CH_FULL};

    res.column    = moc_pkg::POS_W'(emit_col);
    res.row       = moc_pkg::POS_W'(emit_row);
    res.frame_end = (t - w) >= total;
    composites_due = {composites_due, res};

    if (res.frame_end) begin
      frame_pos = 0;
      emit_col  = 0;
      emit_row  = 0;
    end else begin
      frame_pos = t + 1;
      if (emit_col + 1 >= w) begin
        emit_col = 0;
        emit_row = emit_row + 1;
      end else begin
        emit_col = emit_col + 1;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: compare each accepted transaction with the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_composite(composite_t got);
    composite_t want;
    if (composites_due.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: composite pixel with none predicted: col %0d row %0d rgba %h%h%h%h",
                 $realtime, got.column, got.row, got.red, got.green, got.blue, got.alpha);
      return;
    end
    want = composites_due.pop_front();
    if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
        got.alpha !== want.alpha || got.column !== want.column || got.row !== want.row ||
        got.frame_end !== want.frame_end) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display({"%0t: composite mismatch: expected rgba %h%h%h%h (%0d,%0d) last %b,",
                  " got rgba %h%h%h%h (%0d,%0d) last %b"},
                 $realtime, want.red, want.green, want.blue, want.alpha, want.column,
                 want.row, want.frame_end, got.red, got.green, got.blue, got.alpha,
                 got.column, got.row, got.frame_end);
    end
  endfunction

  // Per-transaction random wait, with occasional runs of no waiting at all
  function automatic int draw_wait(ref int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(8, 48);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  int          rx_gap;
  int          rx_run;
  int          hold_left;
  int unsigned hold_token;   // bumped by a test to request one long stall
  int unsigned hold_seen;

  // Sink: sample the transaction of this edge, then decide ready for the next.
  // A long stall is counted here, independent of what the sender is doing.
  always @(posedge clk) begin
    composite_t got;
    logic       taken;
    if (rst) begin
      rx_ready  <= 1'b0;
      rx_gap    = 0;
      hold_left = 0;
      hold_seen = hold_token;
    end else begin
      taken = comp_if.valid && rx_ready;
      if (taken) begin
        got.red       = comp_if.out_red;
        got.green     = comp_if.out_green;
        got.blue      = comp_if.out_blue;
        got.alpha     = comp_if.out_alpha;
        got.column    = comp_if.column;
        got.row       = comp_if.row;
        got.frame_end = comp_if.frame_last;
        check_composite(got);
        rx_gap = draw_wait(rx_run);
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  int unsigned cycle_count;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mask_overlay_compositor_3x3 verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // Every task here starts and ends just after a rising edge. valid stays high
  // between back-to-back transactions so it never gets two updates in one step.
  // --------------------------------------------------------------------------
  int   tx_run;
  logic tx_burst = 1'b0;   // sender offers with no gaps at all

  task automatic send_pixel(pixel_txn_t txn);
    int gap;
    gap = tx_burst ? 0 : draw_wait(tx_run);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid         <= 1'b1;
    pix_if.mode          <= txn.flush;
    pix_if.base_red      <= txn.red;
    pix_if.base_green    <= txn.green;
    pix_if.base_blue     <= txn.blue;
    pix_if.base_alpha    <= txn.alpha;
    pix_if.team_a_here   <= txn.team_a;
    pix_if.team_b_here   <= txn.team_b;
    pix_if.recorder_here <= txn.recorder;
    pix_if.death_here    <= txn.death;
    do @(posedge clk); while (!pix_if.ready);
    predict_composite(txn);
    items_sent++;
  endtask

  // flags = {death, recorder, team_b, team_a}; rgba = {red, green, blue, alpha}
  function automatic pixel_txn_t pixel_of(logic flush, logic [31:0] rgba, logic [3:0] flags);
    pixel_txn_t txn;
    txn.flush = flush;
    {txn.red, txn.green, txn.blue, txn.alpha} = rgba;
    {txn.death, txn.recorder, txn.team_b, txn.team_a} = flags;
    return txn;
  endfunction

  // Flushes are rare inside the image; past it, pixel and flush are equally likely
  function automatic pixel_txn_t random_pixel(int death_per_mille);
    pixel_txn_t txn;
    logic       in_image;
    in_image     = frame_pos < active_width() * active_height();
    txn.flush    = in_image ? ($urandom_range(0, 15) == 0) : 1'($urandom_range(0, 1));
    txn.red      = moc_pkg::CH_W'($urandom_range(0, 255));
    txn.green    = moc_pkg::CH_W'($urandom_range(0, 255));
    txn.blue     = moc_pkg::CH_W'($urandom_range(0, 255));
    txn.alpha    = moc_pkg::CH_W'($urandom_range(0, 255));
    txn.team_a   = 1'($urandom_range(0, 1));
    txn.team_b   = 1'($urandom_range(0, 1));
    txn.recorder = $urandom_range(0, 3) == 0;
    txn.death    = $urandom_range(0, 999) < death_per_mille;
    return txn;
  endfunction

  task automatic send_run(int count, int death_per_mille);
    repeat (count) send_pixel(random_pixel(death_per_mille));
  endtask

  // Drop valid, let every predicted pixel arrive, then cover the back-end latency
  // so a trailing transaction that emits nothing is out of the block as well.
  task automatic wait_settled();
    pix_if.valid <= 1'b0;
    while (composites_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Any register write restarts the frame
  task automatic write_reg(logic [moc_pkg::CFG_INDEX_W-1:0] idx,
                           logic [moc_pkg::DIM_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == moc_pkg::REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    frame_pos = 0;
    emit_col  = 0;
    emit_row  = 0;
    @(posedge clk);
  endtask

  task automatic set_image(logic [moc_pkg::DIM_W-1:0] w, logic [moc_pkg::DIM_W-1:0] h);
    write_reg(moc_pkg::REG_IMAGE_WIDTH, w);
    write_reg(moc_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset size is 500x500: the first 501 transactions of a frame emit nothing
  task automatic test_reset_size();
    send_run(20, 100);
    wait_settled();
  endtask

  // 3x3 image, hand-picked: every overlay rule, flushes inside and past the
  // image, ignored pixel data during the drain, death at corner and edge
  task automatic test_overlay_rules();
    set_image(3, 3);
    send_pixel(pixel_of(1'b0, 32'hFFFF_FFFF, 4'b0000));  // no flags: background, all ones
    send_pixel(pixel_of(1'b0, $urandom, 4'b0001));       // team A only: green
    send_pixel(pixel_of(1'b0, $urandom, 4'b0010));       // team B only: red
    send_pixel(pixel_of(1'b0, 32'h0000_0000, 4'b0011));  // both teams: background, all zeros
    send_pixel(pixel_of(1'b0, $urandom, 4'b0100));       // recorder: blue
    send_pixel(pixel_of(1'b1, $urandom, 4'b1111));       // flush inside image: blank pixel
    send_pixel(pixel_of(1'b0, $urandom, 4'b0110));       // recorder over team B
    send_pixel(pixel_of(1'b0, $urandom, 4'b0111));       // recorder over both teams
    send_pixel(pixel_of(1'b0, $urandom, 4'b1000));       // death in bottom-right corner
    // drain slots: pixel data here must not leak into the frame
    send_pixel(pixel_of(1'b0, $urandom, 4'b1111));
    send_pixel(pixel_of(1'b1, $urandom, 4'b1111));
    send_pixel(pixel_of(1'b0, $urandom, 4'b1001));
    send_pixel(pixel_of(1'b1, $urandom, 4'b0000));
    // second frame: death in top-left corner and on the right edge
    for (int i = 0; i < 9; i++)
      send_pixel(pixel_of(1'b0, $urandom, {i == 0 || i == 5, 3'($urandom_range(0, 7))}));
    repeat (4)
      send_pixel(pixel_of(1'($urandom_range(0, 1)), $urandom, 4'($urandom_range(0, 15))));
    wait_settled();
  endtask

  // Size extremes, including the clamped raw values 0 and 1023
  task automatic test_size_extremes();
    set_image(0, 1023);          // one column, 512 rows
    send_run(frame_items(), 80);
    wait_settled();
    set_image(1023, 0);          // 512 columns, one row
    send_run(frame_items(), 80);
    wait_settled();
    set_image(1, 1);             // single pixel, frames back to back
    send_run(3 * frame_items(), 300);
    wait_settled();
    set_image(2, 1);
    send_run(2 * frame_items(), 300);
    wait_settled();
    write_reg(moc_pkg::REG_IMAGE_HEIGHT, 2);  // 2x2
    send_run(2 * frame_items(), 200);
    wait_settled();
  endtask

  // Output held off for a long stretch while the sender never pauses:
  // the queue fills and the input has to stall
  task automatic test_output_stall();
    set_image(4, 6);
    tx_burst   = 1'b1;
    hold_token <= hold_token + 1;
    send_run(2 * frame_items(), 100);
    tx_burst   = 1'b0;
    wait_settled();
  endtask

  // Random sizes, mostly small; whole frames with random content, some back
  // to back, some cut short and restarted by a register write
  task automatic test_random_frames();
    int unsigned               start;
    int                        frames, death_level;
    logic [moc_pkg::DIM_W-1:0] w, h;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          w = moc_pkg::DIM_W'($urandom_range(17, 64));
          h = moc_pkg::DIM_W'($urandom_range(1, 4));
        end
        1: begin
          w = moc_pkg::DIM_W'($urandom_range(1, 3));
          h = moc_pkg::DIM_W'($urandom_range(17, 40));
        end
        default: begin
          w = moc_pkg::DIM_W'($urandom_range(1, 16));
          h = moc_pkg::DIM_W'($urandom_range(1, 12));
        end
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(moc_pkg::REG_IMAGE_WIDTH, w);
        1:       write_reg(moc_pkg::REG_IMAGE_HEIGHT, h);
        default: set_image(w, h);
      endcase
      case ($urandom_range(0, 3))
        0:       death_level = 0;
        1:       death_level = 25;
        2:       death_level = 100;
        default: death_level = 350;
      endcase
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_run($urandom_range(1, frame_items() - 1), death_level);
          break;
        end
        send_run(frame_items(), death_level);
      end
      wait_settled();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    pix_if.valid         = 1'b0;
    pix_if.mode          = 1'b0;
    pix_if.base_red      = '0;
    pix_if.base_green    = '0;
    pix_if.base_blue     = '0;
    pix_if.base_alpha    = '0;
    pix_if.team_a_here   = 1'b0;
    pix_if.team_b_here   = 1'b0;
    pix_if.recorder_here = 1'b0;
    pix_if.death_here    = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_overlay_rules();
    test_size_extremes();
    test_output_stall();
    test_random_frames();

    wait_settled();
    if (error_count == 0 && composites_due.size() == 0) begin
      $display("mask_overlay_compositor_3x3 verification clean");
    end else begin
      $display("mask_overlay_compositor_3x3 verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/moc_pkg.sv
rtl/core/moc_if.sv
rtl/core/moc_front.sv
rtl/core/moc_queue.sv
rtl/core/moc_back.sv
rtl/core/mask_overlay_compositor_3x3.sv
verif/tb_top.sv
